/* sv/bst_pkg.sv */
package bst_pkg;

    localparam int RING_SAMPLES = 4096;
    localparam int POS_W        = $clog2(RING_SAMPLES);

    localparam int FREQ_W = 16;
    localparam int RATE_W = 18;
    localparam int AMP_W  = 15;
    localparam int SMP_W  = 16;

    // Period is a quotient of the sample rate, half period one bit narrower.
    localparam int PER_W  = RATE_W;
    localparam int N_W    = PER_W - 1;
    localparam int PROD_W = POS_W + N_W;
    localparam int NUM_W  = PROD_W + 4 + AMP_W;
    localparam int DEN_W  = 2 * N_W + 3;
    localparam int Q_W    = AMP_W + 1;
    localparam int DSH_W  = DEN_W + Q_W - 1;
    localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int MP_W   = N_W;
    localparam int CNT_W  = $clog2(PER_W + 1);

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_TONE_FREQ   = 2'd0;
    localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;
    localparam logic [IDX_W-1:0] REG_AMPLITUDE   = 2'd2;

    localparam logic [FREQ_W-1:0] TONE_FREQ_RST   = 16'd0;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd48000;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd28000;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic [RATE_W-1:0] sample_rate;
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic restart;
        logic take;
    } ctrl_t;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic [SMP_W-1:0]  sample;
    } stat_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PER  = 10'b0000000010,
        S_MOD  = 10'b0000000100,
        S_FOLD = 10'b0000001000,
        S_MUL1 = 10'b0000010000,
        S_MUL2 = 10'b0000100000,
        S_SQR  = 10'b0001000000,
        S_DEN  = 10'b0010000000,
        S_DIV  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

endpackage

/* sv/bst_tick_if.sv */
interface bst_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

/* sv/bst_audio_if.sv */
interface bst_audio_if;
    logic                                valid;
    logic                                ready;
    logic signed [bst_pkg::SMP_W-1:0]    left_sample;
    logic signed [bst_pkg::SMP_W-1:0]    right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

/* sv/bst_core.sv */
module bst_core (
    input  logic           clk,
    input  logic           rst_n,
    input  bst_pkg::cfg_t  cfg,
    input  bst_pkg::ctrl_t ctrl,
    output bst_pkg::stat_t stat
);

    bst_pkg::state_t state_reg, state_next;

    logic [bst_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bst_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [bst_pkg::PER_W-1:0]  shr_reg, shr_next;
    logic [bst_pkg::PER_W-1:0]  rem_reg, rem_next;
    logic [bst_pkg::PER_W-1:0]  per_reg, per_next;
    logic [bst_pkg::POS_W-1:0]  x_reg, x_next;
    logic [bst_pkg::N_W-1:0]    n_reg, n_next;
    logic                       neg_reg, neg_next;
    logic [bst_pkg::MP_W-1:0]   mp_reg, mp_next;
    logic [bst_pkg::NUM_W-1:0]  mc_reg, mc_next;
    logic [bst_pkg::NUM_W-1:0]  acc_reg, acc_next;
    logic [bst_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [bst_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [bst_pkg::DSH_W-1:0]  dsh_reg, dsh_next;
    logic [bst_pkg::Q_W-1:0]    q_reg, q_next;
    logic [bst_pkg::SMP_W-1:0]  smp_reg, smp_next;

    logic [bst_pkg::POS_W-1:0]  pos_used;
    logic [bst_pkg::PER_W:0]    dv_trial;
    logic [bst_pkg::PER_W:0]    dv_divisor;
    logic                       dv_fits;
    logic [bst_pkg::PER_W-1:0]  dv_rem;
    logic [bst_pkg::PER_W-1:0]  dv_quo;
    logic [bst_pkg::NUM_W-1:0]  mul_acc;
    logic [bst_pkg::N_W-1:0]    fold_n;
    logic [bst_pkg::PER_W-1:0]  fold_x;
    logic                       fold_hi;
    logic [bst_pkg::DEN_W-1:0]  den;
    logic                       qd_fits;
    logic [bst_pkg::Q_W-1:0]    qd_quo;

    // Shared restoring divider step for the period and the position modulo.
    always_comb
    begin
        dv_trial   = {rem_reg, shr_reg[bst_pkg::PER_W-1]};
        dv_divisor = state_reg == bst_pkg::S_PER
                   ? (bst_pkg::PER_W+1)'(cfg.tone_freq)
                   : {1'b0, per_reg};
        dv_fits    = dv_trial >= dv_divisor;
        dv_rem     = dv_fits ? bst_pkg::PER_W'(dv_trial - dv_divisor)
                             : dv_trial[bst_pkg::PER_W-1:0];
        dv_quo     = {shr_reg[bst_pkg::PER_W-2:0], dv_fits};
    end

    // Shift-add multiplier step, one multiplier bit per cycle.
    assign mul_acc = mp_reg[0] ? acc_reg + mc_reg : acc_reg;

    always_comb
    begin
        fold_n  = per_reg[bst_pkg::PER_W-1:1];
        fold_hi = rem_reg >= {1'b0, per_reg[bst_pkg::PER_W-1:1]};
        fold_x  = fold_hi ? rem_reg - {1'b0, fold_n} : rem_reg;
    end

    assign den = acc_reg[bst_pkg::DEN_W-1:0]
               - bst_pkg::DEN_W'({prod_reg, 2'b00});

    // Quotient of the half-wave formula, one bit per cycle from the top.
    assign qd_fits = bst_pkg::CMP_W'(num_reg) >= bst_pkg::CMP_W'(dsh_reg);
    assign qd_quo  = {q_reg[bst_pkg::Q_W-2:0], qd_fits};

    assign pos_used = ctrl.restart ? '0 : pos_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        shr_next   = shr_reg;
        rem_next   = rem_reg;
        per_next   = per_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        neg_next   = neg_reg;
        mp_next    = mp_reg;
        mc_next    = mc_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        smp_next   = smp_reg;

        case (state_reg)
            bst_pkg::S_IDLE:
            begin
                if (ctrl.start)
                begin
                    if (pos_used == bst_pkg::POS_W'(bst_pkg::RING_SAMPLES - 1))
                        pos_next = '0;
                    else
                        pos_next = pos_used + 1'b1;
                    x_next = pos_used;
                    if (cfg.tone_freq == '0)
                    begin
                        smp_next   = '0;
                        state_next = bst_pkg::S_DONE;
                    end
                    else
                    begin
                        shr_next   = cfg.sample_rate;
                        rem_next   = '0;
                        cnt_next   = bst_pkg::CNT_W'(bst_pkg::PER_W - 1);
                        state_next = bst_pkg::S_PER;
                    end
                end
            end

            bst_pkg::S_PER:
            begin
                shr_next = dv_quo;
                rem_next = dv_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    per_next = dv_quo;
                    if (dv_quo < bst_pkg::PER_W'(2))
                    begin
                        smp_next   = '0;
                        state_next = bst_pkg::S_DONE;
                    end
                    else
                    begin
                        shr_next   = {x_reg, {(bst_pkg::PER_W - bst_pkg::POS_W){1'b0}}};
                        rem_next   = '0;
                        cnt_next   = bst_pkg::CNT_W'(bst_pkg::POS_W - 1);
                        state_next = bst_pkg::S_MOD;
                    end
                end
            end

            bst_pkg::S_MOD:
            begin
                shr_next = dv_quo;
                rem_next = dv_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bst_pkg::S_FOLD;
            end

            bst_pkg::S_FOLD:
            begin
                // The edges of each half period give zero.
                if (fold_x == '0 || fold_x >= {1'b0, fold_n})
                begin
                    smp_next   = '0;
                    state_next = bst_pkg::S_DONE;
                end
                else
                begin
                    x_next     = fold_x[bst_pkg::POS_W-1:0];
                    n_next     = fold_n;
                    neg_next   = fold_hi;
                    mp_next    = bst_pkg::MP_W'(fold_x[bst_pkg::POS_W-1:0]);
                    mc_next    = bst_pkg::NUM_W'(fold_n - fold_x[bst_pkg::N_W-1:0]);
                    acc_next   = '0;
                    cnt_next   = bst_pkg::CNT_W'(bst_pkg::POS_W - 1);
                    state_next = bst_pkg::S_MUL1;
                end
            end

            bst_pkg::S_MUL1:
            begin
                acc_next = mul_acc;
                mc_next  = {mc_reg[bst_pkg::NUM_W-2:0], 1'b0};
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    prod_next  = mul_acc[bst_pkg::PROD_W-1:0];
                    mp_next    = bst_pkg::MP_W'(cfg.amplitude);
                    mc_next    = bst_pkg::NUM_W'({mul_acc[bst_pkg::PROD_W-1:0], 4'b0000});
                    acc_next   = '0;
                    cnt_next   = bst_pkg::CNT_W'(bst_pkg::AMP_W - 1);
                    state_next = bst_pkg::S_MUL2;
                end
            end

            bst_pkg::S_MUL2:
            begin
                acc_next = mul_acc;
                mc_next  = {mc_reg[bst_pkg::NUM_W-2:0], 1'b0};
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    num_next   = mul_acc;
                    mp_next    = n_reg;
                    mc_next    = bst_pkg::NUM_W'(n_reg) + bst_pkg::NUM_W'({n_reg, 2'b00});
                    acc_next   = '0;
                    cnt_next   = bst_pkg::CNT_W'(bst_pkg::N_W - 1);
                    state_next = bst_pkg::S_SQR;
                end
            end

            bst_pkg::S_SQR:
            begin
                // Multiplicand is 5N, so the product is 5N^2 directly.
                acc_next = mul_acc;
                mc_next  = {mc_reg[bst_pkg::NUM_W-2:0], 1'b0};
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bst_pkg::S_DEN;
            end

            bst_pkg::S_DEN:
            begin
                dsh_next   = {den, {(bst_pkg::Q_W - 1){1'b0}}};
                q_next     = '0;
                cnt_next   = bst_pkg::CNT_W'(bst_pkg::Q_W - 1);
                state_next = bst_pkg::S_DIV;
            end

            bst_pkg::S_DIV:
            begin
                if (qd_fits)
                    num_next = num_reg - dsh_reg[bst_pkg::NUM_W-1:0];
                q_next   = qd_quo;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    smp_next   = neg_reg ? bst_pkg::SMP_W'(~qd_quo + 1'b1)
                                         : bst_pkg::SMP_W'(qd_quo);
                    state_next = bst_pkg::S_DONE;
                end
            end

            bst_pkg::S_DONE:
            begin
                if (ctrl.take)
                    state_next = bst_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bst_pkg::S_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shr_reg  <= shr_next;
        rem_reg  <= rem_next;
        per_reg  <= per_next;
        x_reg    <= x_next;
        n_reg    <= n_next;
        neg_reg  <= neg_next;
        mp_reg   <= mp_next;
        mc_reg   <= mc_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        smp_reg  <= smp_next;
    end

    assign stat.idle   = state_reg == bst_pkg::S_IDLE;
    assign stat.done   = state_reg == bst_pkg::S_DONE;
    assign stat.sample = smp_reg;

endmodule

/* sv/bhaskara_sine_tone_generator.sv */
// An accepted tick yields its sample after the bit-serial divider (18 + 12 steps), three
// shift-add multiplies (12 + 15 + 17 steps) and the 16-step quotient loop for an audible
// tone; silent samples skip the rest of that sequence.
// One item at a time: the next tick is taken once the previous sample sits in the
// output register. Reset (rst_n low, asynchronous) clears the sample position and loads
// tone_freq 0, sample_rate 48000 and amplitude 28000.
module bhaskara_sine_tone_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bst_pkg::ADDR_W-1:0]   paddr,
    input  logic [bst_pkg::DATA_W-1:0]   pwdata,
    output logic [bst_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    bst_tick_if.sink                     tick,
    bst_audio_if.source                  audio
);

    bst_pkg::cfg_t  cfg_reg, cfg_next;
    bst_pkg::ctrl_t ctrl;
    bst_pkg::stat_t stat;

    logic                       out_valid_reg, out_valid_next;
    logic [bst_pkg::SMP_W-1:0]  out_smp_reg, out_smp_next;
    logic                       wr_en;
    logic [bst_pkg::IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[bst_pkg::IDX_W+1:2];
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                bst_pkg::REG_TONE_FREQ:
                    cfg_next.tone_freq = pwdata[bst_pkg::FREQ_W-1:0];
                bst_pkg::REG_SAMPLE_RATE:
                    cfg_next.sample_rate = pwdata[bst_pkg::RATE_W-1:0];
                bst_pkg::REG_AMPLITUDE:
                    cfg_next.amplitude = pwdata[bst_pkg::AMP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bst_pkg::REG_TONE_FREQ:   prdata = bst_pkg::DATA_W'(cfg_reg.tone_freq);
            bst_pkg::REG_SAMPLE_RATE: prdata = bst_pkg::DATA_W'(cfg_reg.sample_rate);
            bst_pkg::REG_AMPLITUDE:   prdata = bst_pkg::DATA_W'(cfg_reg.amplitude);
            default:                  prdata = '0;
        endcase
    end

    assign tick.ready   = stat.idle;
    assign ctrl.start   = tick.valid & stat.idle;
    assign ctrl.restart = tick.restart;
    // A finished sample moves on only when the output register is free or being emptied.
    assign ctrl.take    = stat.done & (~out_valid_reg | audio.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_smp_next   = out_smp_reg;
        if (ctrl.take)
        begin
            out_valid_next = 1'b1;
            out_smp_next   = stat.sample;
        end
        else if (audio.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    bst_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tone_freq   <= bst_pkg::TONE_FREQ_RST;
            cfg_reg.sample_rate <= bst_pkg::SAMPLE_RATE_RST;
            cfg_reg.amplitude   <= bst_pkg::AMPLITUDE_RST;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_smp_reg <= out_smp_next;
    end

    assign audio.valid        = out_valid_reg;
    assign audio.left_sample  = out_smp_reg;
    assign audio.right_sample = out_smp_reg;

endmodule
